// ===== sv/round_robin_thread_scheduler_top_assert.svh =====
// Assertion macros for the run-queue scheduler.
// Depends on nothing; included inside module bodies.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_TOP_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_TOP_ASSERT_SVH

// implication checked at every edge outside reset
`define RRTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// plain invariant checked at every edge outside reset
`define RRTS_ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

`endif

// ===== sv/rrts_pkg.sv =====
// Shared types and codes for the run-queue scheduler.
// No dependencies.
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int MAX_THREADS = 64;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_YIELD = 2'd1;
  localparam logic [1:0] CMD_MKRUN = 2'd2;
  localparam logic [1:0] CMD_START = 2'd3;

  localparam logic [2:0] ST_RUNNING  = 3'd0;
  localparam logic [2:0] ST_RUNNABLE = 3'd1;
  localparam logic [2:0] ST_DEAD     = 3'd4;
  localparam logic [2:0] ST_UNINIT   = 3'd5;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_BAD_STAT  = 3'd1;
  localparam logic [2:0] ERR_NOT_RUNBL = 3'd2;
  localparam logic [2:0] ERR_ALREADY   = 3'd3;
  localparam logic [2:0] ERR_EMPTY     = 3'd4;
  localparam logic [2:0] ERR_NO_INIT   = 3'd5;

  localparam logic [7:0] SLICE_RESET = 8'd2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CHK  = 8'b0000_0010,
    S_MOD  = 8'b0000_0100,
    S_ENQ  = 8'b0000_1000,
    S_ULA  = 8'b0001_0000,
    S_ULB  = 8'b0010_0000,
    S_RUN  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } seq_state_t;

endpackage

// ===== sv/round_robin_thread_scheduler_top.sv =====
// Round-robin run-queue scheduler: status table, linked run queue, sequencer.
// Depends on rrts_pkg and round_robin_thread_scheduler_top_assert.svh.
//
// Use: one command beat in on the in_ channel (valid/ready), one result beat
// out on the out_ channel. cfg_we writes slice_ticks at once; write it only
// while the block is idle.
// Steps: yield, make-runnable and start pass through a check step on the
// registered status read, then an enqueue step, a two-step unlink and a run
// step as the command needs. A tick on a running thread first takes a
// bit-serial remainder of tick_number by slice_ticks, and when it rotates
// it then takes the enqueue, unlink and run steps.
// Flow: one command at a time; in_ready is high only while the sequencer
// is idle, so a new command is not taken before the last one is through
// its steps. The result sits in an output register, so the next command is
// taken while a result waits; a finished command then holds in its last
// step until out_ready frees the register.
// Reset: synchronous, active low. All threads read as uninitialised through
// per-entry valid bits, the queue is empty and nothing runs; link memories
// are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module round_robin_thread_scheduler_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_slice_ticks,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [5:0] in_thread_id,
  input  logic       in_target_valid,
  input  logic [2:0] in_yield_status,
  input  logic       in_enqueue_only,
  input  logic [31:0] in_tick_number,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_error_code,
  output logic [5:0] out_running_id,
  output logic       out_running_valid,
  output logic       out_switched,
  output logic [5:0] out_previous_id,
  output logic [6:0] out_queue_count
);
  import rrts_pkg::*;

  localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

  seq_state_t state_r, state_nxt;

  logic [7:0]    slice_r;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt, cur_r, cur_nxt;
  logic [6:0]    count_r, count_nxt;
  logic          cur_vld_r, cur_vld_nxt, started_r, started_nxt;

  // captured command
  logic [1:0]    cmd_r;
  logic [IW-1:0] tid_r;
  logic          oor_r, tvalid_r, ssafe_r;
  logic [2:0]    sstat_r;
  logic [31:0]   div_r;
  logic [7:0]    rem_r;
  logic [4:0]    bit_cnt_r;

  // plan
  logic          had_r;
  logic [IW-1:0] prev_id_r;
  logic [2:0]    err_r;
  logic          enq_r, ul_r, ul_head_r, run_r;
  logic [IW-1:0] enq_id_r, ul_id_r, run_id_r;

  // memories
  logic [2:0]    st_mem [MAX_THREADS];
  logic [MAX_THREADS-1:0] st_vld_r;
  logic [IW-1:0] nx_mem [MAX_THREADS];
  logic [IW-1:0] pv_mem [MAX_THREADS];
  logic [2:0]    st_q;
  logic          st_qv;
  logic [IW-1:0] nxt_q, prv_q;
  logic [2:0]    st_rd;

  logic          st_we, nx_we, pv_we;
  logic [IW-1:0] st_wa, nx_wa, pv_wa, nx_wd, pv_wd;
  logic [2:0]    st_wd;

  logic          accept, out_load;
  logic          oor_c;
  logic [IW-1:0] tid_c;

  // plan from the check step
  logic          p_enq, p_ul, p_ul_head, p_run, p_wst, p_mod, p_start;
  logic [IW-1:0] p_enq_id, p_ul_id, p_run_id;
  logic [2:0]    p_err;
  logic          tid_is_cur, tid_queued;

  // remainder step
  logic [7:0]    slice_eff;
  logic [8:0]    rem_sh;
  logic [7:0]    rem_new;
  logic          rot;
  logic [IW-1:0] ul_y;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid || out_ready);

  assign oor_c = int'(in_thread_id) >= MAX_THREADS;
  assign tid_c = oor_c ? '0 : IW'(in_thread_id);
  assign st_rd = st_qv ? st_q : ST_UNINIT;

  assign slice_eff = (slice_r == 8'd0) ? 8'd1 : slice_r;
  assign rem_sh    = {rem_r, div_r[31]};
  assign rem_new   = (rem_sh >= {1'b0, slice_eff}) ? 8'(rem_sh - {1'b0, slice_eff})
                                                   : rem_sh[7:0];
  assign rot       = (rem_new == 8'd0);
  assign ul_y      = ul_head_r ? head_r : ul_id_r;

  assign tid_is_cur = (tid_r == cur_r);
  assign tid_queued = tid_is_cur ? (sstat_r == ST_RUNNABLE) : (st_rd == ST_RUNNABLE);

  always_comb begin
    p_err = ERR_OK;
    p_enq = 1'b0; p_enq_id = cur_r;
    p_ul = 1'b0; p_ul_head = 1'b0; p_ul_id = tid_r;
    p_run = 1'b0; p_run_id = tid_r;
    p_wst = 1'b0; p_mod = 1'b0; p_start = 1'b0;
    unique case (cmd_r)
      CMD_TICK: begin
        if (!started_r) p_err = ERR_NO_INIT;
        else if (cur_vld_r) p_mod = 1'b1;
      end
      CMD_YIELD: begin
        if (!started_r || !cur_vld_r) begin
          p_err = ERR_NO_INIT;
        end else if (sstat_r < ST_RUNNABLE || sstat_r > ST_DEAD) begin
          p_err = ERR_BAD_STAT;
        end else if (tvalid_r && (oor_r ||
                     (st_rd != ST_RUNNABLE && st_rd != ST_RUNNING))) begin
          p_err = ERR_NOT_RUNBL;
        end else if (!tvalid_r && sstat_r != ST_RUNNABLE && count_r == 7'd0) begin
          p_err = ERR_EMPTY;
        end else begin
          p_wst = (sstat_r != ST_RUNNABLE);
          p_enq = (sstat_r == ST_RUNNABLE);
          p_run = 1'b1;
          if (tvalid_r) begin
            p_ul = tid_queued;
          end else begin
            p_ul = 1'b1;
            p_ul_head = 1'b1;
          end
        end
      end
      CMD_MKRUN: begin
        if (oor_r) begin
          p_err = ERR_NOT_RUNBL;
        end else begin
          p_start = 1'b1;
          if (st_rd == ST_RUNNABLE || st_rd == ST_RUNNING) begin
            p_err = ERR_ALREADY;
          end else if (st_rd == ST_UNINIT || ssafe_r || !cur_vld_r) begin
            p_enq = 1'b1;
            p_enq_id = tid_r;
          end else begin
            p_enq = 1'b1;
            p_run = 1'b1;
          end
        end
      end
      CMD_START: begin
        if (!started_r) p_err = ERR_NO_INIT;
        else if (cur_vld_r) p_err = ERR_OK;
        else if (count_r == 7'd0) p_err = ERR_EMPTY;
        else begin
          p_ul = 1'b1;
          p_ul_head = 1'b1;
          p_run = 1'b1;
        end
      end
      default: p_err = ERR_OK;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    started_nxt = started_r;
    st_we = 1'b0; st_wa = cur_r; st_wd = sstat_r;
    nx_we = 1'b0; nx_wa = tail_r; nx_wd = enq_id_r;
    pv_we = 1'b0; pv_wa = enq_id_r; pv_wd = tail_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_CHK;
      S_CHK: begin
        if (p_start) started_nxt = 1'b1;
        st_we = p_wst;
        if (p_mod) state_nxt = S_MOD;
        else if (p_enq) state_nxt = S_ENQ;
        else if (p_ul) state_nxt = S_ULA;
        else if (p_run) state_nxt = S_RUN;
        else state_nxt = S_DONE;
      end
      S_MOD: begin
        if (bit_cnt_r == 5'd31) state_nxt = rot ? S_ENQ : S_DONE;
      end
      S_ENQ: begin
        st_we = 1'b1; st_wa = enq_id_r; st_wd = ST_RUNNABLE;
        if (count_r == 7'd0) begin
          head_nxt = enq_id_r;
        end else begin
          nx_we = 1'b1;
          pv_we = 1'b1;
        end
        tail_nxt  = enq_id_r;
        count_nxt = count_r + 7'd1;
        if (ul_r) state_nxt = S_ULA;
        else if (run_r) state_nxt = S_RUN;
        else state_nxt = S_DONE;
      end
      S_ULA: state_nxt = S_ULB;
      S_ULB: begin
        if (ul_id_r == head_r) head_nxt = nxt_q;
        else begin
          nx_we = 1'b1; nx_wa = prv_q; nx_wd = nxt_q;
        end
        if (ul_id_r == tail_r) tail_nxt = prv_q;
        else begin
          pv_we = 1'b1; pv_wa = nxt_q; pv_wd = prv_q;
        end
        count_nxt = count_r - 7'd1;
        if (count_r == 7'd1) begin
          head_nxt = '0;
          tail_nxt = '0;
        end
        state_nxt = run_r ? S_RUN : S_DONE;
      end
      S_RUN: begin
        st_we = 1'b1; st_wa = run_id_r; st_wd = ST_RUNNING;
        cur_nxt     = run_id_r;
        cur_vld_nxt = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      slice_r   <= SLICE_RESET;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      cur_r     <= '0;
      cur_vld_r <= 1'b0;
      started_r <= 1'b0;
      st_vld_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      cur_r     <= cur_nxt;
      cur_vld_r <= cur_vld_nxt;
      started_r <= started_nxt;
      if (cfg_we) slice_r <= cfg_slice_ticks;
      if (st_we) st_vld_r[st_wa] <= 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // status and link memories
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    if (accept) begin
      st_q  <= st_mem[tid_c];
      st_qv <= st_vld_r[tid_c];
    end
    if (state_r == S_ULA) begin
      nxt_q <= nx_mem[ul_y];
      prv_q <= pv_mem[ul_y];
    end
  end

  // command capture and plan
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      tid_r    <= tid_c;
      oor_r    <= oor_c;
      tvalid_r <= in_target_valid;
      sstat_r  <= in_yield_status;
      ssafe_r  <= in_enqueue_only;
      div_r    <= in_tick_number;
    end
    if (state_r == S_CHK) begin
      had_r     <= cur_vld_r;
      prev_id_r <= cur_vld_r ? cur_r : '0;
      err_r     <= p_err;
      enq_r     <= p_enq;
      enq_id_r  <= p_enq_id;
      ul_r      <= p_ul;
      ul_head_r <= p_ul_head;
      ul_id_r   <= p_ul_id;
      run_r     <= p_run;
      run_id_r  <= p_run_id;
      rem_r     <= '0;
      bit_cnt_r <= '0;
    end
    if (state_r == S_MOD) begin
      rem_r     <= rem_new;
      div_r     <= {div_r[30:0], 1'b0};
      bit_cnt_r <= bit_cnt_r + 5'd1;
      if (bit_cnt_r == 5'd31) begin
        enq_r     <= rot;
        enq_id_r  <= cur_r;
        ul_r      <= rot;
        ul_head_r <= 1'b1;
        run_r     <= rot;
      end
    end
    if (state_r == S_ULA) begin
      ul_id_r <= ul_y;
      if (ul_head_r) run_id_r <= ul_y;
    end
    if (out_load) begin
      out_error_code    <= err_r;
      out_running_id    <= cur_vld_r ? 6'(cur_r) : 6'd0;
      out_running_valid <= cur_vld_r;
      out_switched      <= cur_vld_r && (!had_r || cur_r != prev_id_r);
      out_previous_id   <= 6'(prev_id_r);
      out_queue_count   <= count_r;
    end
  end

`include "round_robin_thread_scheduler_top_assert.svh"

  `RRTS_ASSERT_ALWAYS(a_count_range, clk, rst_n, int'(count_r) <= MAX_THREADS)
  `RRTS_ASSERT_IMPL(a_empty_ptrs, clk, rst_n, state_r == S_IDLE && count_r == 7'd0,
    head_r == '0 && tail_r == '0)
  `RRTS_ASSERT_IMPL(a_err_no_switch, clk, rst_n, out_valid && out_error_code != ERR_OK,
    !out_switched)

endmodule

// ===== tb/tb_round_robin_thread_scheduler_top.sv =====
// Self-checking bench for the round-robin run-queue scheduler top level.
// Depends on rrts_pkg and round_robin_thread_scheduler_top; a scoreboard class
// predicts each result beat from its own copy of the thread table and run queue.
`timescale 1ns / 1ps
module tb_round_robin_thread_scheduler_top;
  import rrts_pkg::*;

  localparam logic [2:0] ST_DESCHED = 3'd2;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam int RANDOM_ITEMS = 1880;
  localparam int QUIET_ITEMS = 200;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  thread_id;
    logic        target_valid;
    logic [2:0]  yield_status;
    logic        enqueue_only;
    logic [31:0] tick_number;
  } sched_cmd_t;

  typedef struct packed {
    logic [2:0] error_code;
    logic [5:0] running_id;
    logic       running_valid;
    logic       switched;
    logic [5:0] previous_id;
    logic [6:0] queue_count;
  } sched_res_t;

  class sched_scoreboard;
    logic [7:0] slice;
    logic [2:0] status [64];
    logic [5:0] nxt [64];
    logic [5:0] prv [64];
    bit         queued [64];
    logic [5:0] head, tail, cur;
    logic [6:0] count;
    bit         cur_valid, started;
    sched_res_t expected_q[$];
    int         errors, checked;

    function new();
      slice = SLICE_RESET;
      for (int i = 0; i < 64; i++) begin
        status[i] = ST_UNINIT;
        nxt[i] = '0;
        prv[i] = '0;
        queued[i] = 0;
      end
      head = '0; tail = '0; cur = '0; count = '0;
      cur_valid = 0; started = 0;
      errors = 0; checked = 0;
    endfunction

    function void enqueue(logic [5:0] t);
      status[t] = ST_RUNNABLE;
      if (queued[t]) return;
      if (count == 0) head = t;
      else begin
        nxt[tail] = t;
        prv[t] = tail;
      end
      tail = t;
      queued[t] = 1;
      count++;
    endfunction

    function void unlink(logic [5:0] t);
      if (!queued[t]) return;
      if (t == head) head = nxt[t];
      else nxt[prv[t]] = nxt[t];
      if (t == tail) tail = prv[t];
      else prv[nxt[t]] = prv[t];
      queued[t] = 0;
      count--;
      if (count == 0) begin
        head = '0;
        tail = '0;
      end
    endfunction

    function logic [5:0] pop_head();
      logic [5:0] h;
      h = head;
      unlink(h);
      return h;
    endfunction

    function void run(logic [5:0] t);
      status[t] = ST_RUNNING;
      cur = t;
      cur_valid = 1;
    endfunction

    function void note_command(sched_cmd_t c);
      sched_res_t r;
      bit had;
      logic [5:0] prev, to;
      logic [31:0] sl;
      had = cur_valid;
      prev = had ? cur : 6'd0;
      r.error_code = ERR_OK;
      case (c.cmd)
        CMD_TICK: begin
          sl = (slice == 0) ? 32'd1 : {24'd0, slice};
          if (!started) r.error_code = ERR_NO_INIT;
          else if (had && (c.tick_number % sl) == 0) begin
            enqueue(cur);
            run(pop_head());
          end
        end
        CMD_YIELD: begin
          if (!started || !had) r.error_code = ERR_NO_INIT;
          else if (c.yield_status < 1 || c.yield_status > 4) r.error_code = ERR_BAD_STAT;
          else if (c.target_valid && status[c.thread_id] != ST_RUNNABLE &&
                   status[c.thread_id] != ST_RUNNING) r.error_code = ERR_NOT_RUNBL;
          else if (!c.target_valid && c.yield_status != ST_RUNNABLE && count == 0)
            r.error_code = ERR_EMPTY;
          else begin
            status[cur] = c.yield_status;
            if (c.yield_status == ST_RUNNABLE) enqueue(cur);
            if (c.target_valid) begin
              to = c.thread_id;
              unlink(to);
            end else to = pop_head();
            run(to);
          end
        end
        CMD_MKRUN: begin
          started = 1;
          if (status[c.thread_id] == ST_RUNNABLE || status[c.thread_id] == ST_RUNNING)
            r.error_code = ERR_ALREADY;
          else if (status[c.thread_id] == ST_UNINIT || c.enqueue_only || !had)
            enqueue(c.thread_id);
          else begin
            enqueue(cur);
            run(c.thread_id);
          end
        end
        default: begin
          if (!started) r.error_code = ERR_NO_INIT;
          else if (had) r.error_code = ERR_OK;
          else if (count == 0) r.error_code = ERR_EMPTY;
          else run(pop_head());
        end
      endcase
      r.running_id = cur_valid ? cur : 6'd0;
      r.running_valid = cur_valid;
      r.switched = cur_valid && (!had || cur != prev);
      r.previous_id = prev;
      r.queue_count = count;
      expected_q.push_back(r);
    endfunction

    function void check_result(sched_res_t a);
      sched_res_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (a.error_code !== e.error_code) begin
        $error("error_code: expected %0d, got %0d", e.error_code, a.error_code);
        errors++;
      end
      if (a.running_id !== e.running_id) begin
        $error("running_id: expected %0d, got %0d", e.running_id, a.running_id);
        errors++;
      end
      if (a.running_valid !== e.running_valid) begin
        $error("running_valid: expected %0d, got %0d", e.running_valid, a.running_valid);
        errors++;
      end
      if (a.switched !== e.switched) begin
        $error("switched: expected %0d, got %0d", e.switched, a.switched);
        errors++;
      end
      if (a.previous_id !== e.previous_id) begin
        $error("previous_id: expected %0d, got %0d", e.previous_id, a.previous_id);
        errors++;
      end
      if (a.queue_count !== e.queue_count) begin
        $error("queue_count: expected %0d, got %0d", e.queue_count, a.queue_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [7:0]  cfg_slice_ticks = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_cmd = '0;
  logic [5:0]  in_thread_id = '0;
  logic        in_target_valid = 0;
  logic [2:0]  in_yield_status = '0;
  logic        in_enqueue_only = 0;
  logic [31:0] in_tick_number = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_error_code;
  logic [5:0]  out_running_id;
  logic        out_running_valid;
  logic        out_switched;
  logic [5:0]  out_previous_id;
  logic [6:0]  out_queue_count;

  sched_scoreboard sb = new();
  bit quiet = 0;
  int sent = 0;
  int stall_left = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  round_robin_thread_scheduler_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_slice_ticks(cfg_slice_ticks),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_thread_id(in_thread_id), .in_target_valid(in_target_valid),
    .in_yield_status(in_yield_status), .in_enqueue_only(in_enqueue_only),
    .in_tick_number(in_tick_number),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_error_code(out_error_code), .out_running_id(out_running_id),
    .out_running_valid(out_running_valid), .out_switched(out_switched),
    .out_previous_id(out_previous_id), .out_queue_count(out_queue_count)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result({out_error_code, out_running_id, out_running_valid,
                         out_switched, out_previous_id, out_queue_count});
      if (quiet) out_ready <= 1;
      else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 15) - 1;
        out_ready <= 0;
      end else out_ready <= 1;
    end
  end

  task automatic send_command(sched_cmd_t c);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= c.cmd;
    in_thread_id <= c.thread_id;
    in_target_valid <= c.target_valid;
    in_yield_status <= c.yield_status;
    in_enqueue_only <= c.enqueue_only;
    in_tick_number <= c.tick_number;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_command(c);
    sent++;
  endtask

  task automatic cmd_of(logic [1:0] op, logic [5:0] tid, logic tv, logic [2:0] ss,
                        logic safe, logic [31:0] tick);
    sched_cmd_t c;
    c = '{cmd: op, thread_id: tid, target_valid: tv, yield_status: ss,
          enqueue_only: safe, tick_number: tick};
    send_command(c);
  endtask

  task automatic set_slice(logic [7:0] v);
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1;
    cfg_slice_ticks <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.slice = v;
  endtask

  task automatic random_command();
    sched_cmd_t c;
    int k;
    k = $urandom_range(0, 99);
    c.cmd = (k < 30) ? CMD_TICK : (k < 60) ? CMD_YIELD : (k < 92) ? CMD_MKRUN : CMD_START;
    c.thread_id = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
    c.target_valid = $urandom_range(0, 1);
    c.yield_status = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    c.enqueue_only = $urandom_range(0, 1);
    c.tick_number = ($urandom_range(0, 1) == 0) ? $urandom
                    : 32'($urandom_range(0, 40)) * {24'd0, sb.slice};
    send_command(c);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // before any thread exists
    cmd_of(CMD_TICK, 0, 0, 0, 0, 32'd0);
    cmd_of(CMD_YIELD, 0, 0, ST_RUNNABLE, 0, 0);
    cmd_of(CMD_START, 0, 0, 0, 0, 0);
    cmd_of(CMD_MKRUN, 6'd63, 0, 0, 1, 0);
    cmd_of(CMD_TICK, 0, 0, 0, 0, 32'd0);
    cmd_of(CMD_MKRUN, 6'd0, 0, 0, 0, 0);
    cmd_of(CMD_MKRUN, 6'd0, 0, 0, 0, 0);
    cmd_of(CMD_START, 0, 0, 0, 0, 0);
    cmd_of(CMD_START, 0, 0, 0, 0, 0);
    cmd_of(CMD_TICK, 0, 0, 0, 0, 32'hFFFF_FFFE);
    cmd_of(CMD_TICK, 0, 0, 0, 0, 32'd1);
    for (int s = 0; s < 8; s += 5) cmd_of(CMD_YIELD, 0, 0, 3'(s), 0, 0);
    cmd_of(CMD_YIELD, 0, 0, 3'd6, 0, 0);
    cmd_of(CMD_YIELD, 0, 0, 3'd7, 0, 0);
    cmd_of(CMD_YIELD, 6'd5, 1, ST_BLOCKED, 0, 0);
    cmd_of(CMD_YIELD, 0, 0, ST_BLOCKED, 0, 0);
    cmd_of(CMD_YIELD, 6'd63, 1, ST_RUNNABLE, 0, 0);
    cmd_of(CMD_YIELD, 6'd63, 1, ST_RUNNABLE, 0, 0);
    cmd_of(CMD_MKRUN, 6'd0, 0, 0, 0, 0);
    cmd_of(CMD_YIELD, 6'd0, 1, ST_DESCHED, 0, 0);
    cmd_of(CMD_MKRUN, 6'd63, 0, 0, 0, 0);
    cmd_of(CMD_YIELD, 0, 0, ST_DEAD, 0, 0);
    cmd_of(CMD_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
    set_slice(8'd0);
    cmd_of(CMD_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_slice(8'd1);
        1: set_slice(8'd255);
        2: set_slice(8'd0);
        3: set_slice(8'd3);
        default: set_slice(8'($urandom_range(1, 255)));
      endcase
      for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
        if (ph == 5 && i >= RANDOM_ITEMS / 6 - QUIET_ITEMS) quiet = 1;
        random_command();
      end
    end
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d command beats over six slice settings; %0d result beats checked.",
             sent, sb.checked);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding", sb.expected_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== round_robin_thread_scheduler_top.f =====
+incdir+sv
sv/rrts_pkg.sv
sv/round_robin_thread_scheduler_top.sv
tb/tb_round_robin_thread_scheduler_top.sv
